@@ rtl/core/tbls_pkg.sv @@
// ----------------------------------------------------------------------------
// tbls_pkg
// Shared types, codes and byte constants for the BOM / line ending sniffer.
// ----------------------------------------------------------------------------
package tbls_pkg;

   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int TOTAL_BITS         = 32;   // width of the reported totals

   localparam int BYTE_BITS   = 8;
   localparam int HEAD_BYTES  = 4;
   localparam int HEAD_BITS   = HEAD_BYTES * BYTE_BITS;
   localparam int SEEN_BITS   = 3;           // holds 0..HEAD_BYTES
   localparam int KIND_BITS   = 3;
   localparam int LEN_BITS    = 3;
   localparam int ENDING_BITS = 2;

   // byte order mark kinds
   localparam logic [KIND_BITS-1:0] MARK_NONE    = 3'd0;
   localparam logic [KIND_BITS-1:0] MARK_UTF8    = 3'd1;
   localparam logic [KIND_BITS-1:0] MARK_UTF32BE = 3'd2;
   localparam logic [KIND_BITS-1:0] MARK_UTF32LE = 3'd3;
   localparam logic [KIND_BITS-1:0] MARK_UTF7    = 3'd4;
   localparam logic [KIND_BITS-1:0] MARK_UTF16BE = 3'd5;
   localparam logic [KIND_BITS-1:0] MARK_UTF16LE = 3'd6;

   // line ending codes
   localparam logic [ENDING_BITS-1:0] ENDING_LF   = 2'd0;
   localparam logic [ENDING_BITS-1:0] ENDING_CRLF = 2'd1;
   localparam logic [ENDING_BITS-1:0] ENDING_CR   = 2'd2;

   // bytes of interest
   localparam logic [BYTE_BITS-1:0] BYTE_LF    = 8'h0a;
   localparam logic [BYTE_BITS-1:0] BYTE_CR    = 8'h0d;
   localparam logic [BYTE_BITS-1:0] BYTE_ZERO  = 8'h00;
   localparam logic [BYTE_BITS-1:0] BYTE_EF    = 8'hef;
   localparam logic [BYTE_BITS-1:0] BYTE_BB    = 8'hbb;
   localparam logic [BYTE_BITS-1:0] BYTE_BF    = 8'hbf;
   localparam logic [BYTE_BITS-1:0] BYTE_FE    = 8'hfe;
   localparam logic [BYTE_BITS-1:0] BYTE_FF    = 8'hff;
   localparam logic [BYTE_BITS-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [BYTE_BITS-1:0] CHAR_SLASH = 8'h2f;
   localparam logic [BYTE_BITS-1:0] CHAR_V     = 8'h76;
   localparam logic [BYTE_BITS-1:0] CHAR_EIGHT = 8'h38;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE  = 8'h39;

   // step control from the input register to the tally
   typedef struct packed {
      logic advance;   // input register hands its beat on this cycle
      logic last;      // that beat closes the buffer
   } step_ctrl_type;

   // decoded mark
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [LEN_BITS-1:0]  length;
   } mark_type;

endpackage

@@ rtl/core/tbls_mark_decode.sv @@
// ----------------------------------------------------------------------------
// tbls_mark_decode
// Priority match of the buffer head against the known byte order marks.
// ----------------------------------------------------------------------------
module tbls_mark_decode (
   input  logic [tbls_pkg::HEAD_BITS-1:0] head_bytes,
   input  logic [tbls_pkg::SEEN_BITS-1:0] bytes_seen,
   output tbls_pkg::mark_type             mark
);

   logic [tbls_pkg::BYTE_BITS-1:0] b0, b1, b2, b3;
   logic has2, has3, has4;

   assign b0 = head_bytes[0*tbls_pkg::BYTE_BITS +: tbls_pkg::BYTE_BITS];
   assign b1 = head_bytes[1*tbls_pkg::BYTE_BITS +: tbls_pkg::BYTE_BITS];
   assign b2 = head_bytes[2*tbls_pkg::BYTE_BITS +: tbls_pkg::BYTE_BITS];
   assign b3 = head_bytes[3*tbls_pkg::BYTE_BITS +: tbls_pkg::BYTE_BITS];

   assign has2 = (bytes_seen >= tbls_pkg::SEEN_BITS'(2));
   assign has3 = (bytes_seen >= tbls_pkg::SEEN_BITS'(3));
   assign has4 = (bytes_seen >= tbls_pkg::SEEN_BITS'(4));

   always_comb begin
      mark.kind   = tbls_pkg::MARK_NONE;
      mark.length = tbls_pkg::LEN_BITS'(0);
      if (has3 && b0 == tbls_pkg::BYTE_EF && b1 == tbls_pkg::BYTE_BB
          && b2 == tbls_pkg::BYTE_BF) begin
         mark.kind   = tbls_pkg::MARK_UTF8;
         mark.length = tbls_pkg::LEN_BITS'(3);
      end else if (has4 && b0 == tbls_pkg::BYTE_ZERO && b1 == tbls_pkg::BYTE_ZERO
                   && b2 == tbls_pkg::BYTE_FE && b3 == tbls_pkg::BYTE_FF) begin
         mark.kind   = tbls_pkg::MARK_UTF32BE;
         mark.length = tbls_pkg::LEN_BITS'(4);
      end else if (has4 && b0 == tbls_pkg::BYTE_FF && b1 == tbls_pkg::BYTE_FE
                   && b2 == tbls_pkg::BYTE_ZERO && b3 == tbls_pkg::BYTE_ZERO) begin
         mark.kind   = tbls_pkg::MARK_UTF32LE;
         mark.length = tbls_pkg::LEN_BITS'(4);
      end else if (has4 && b0 == tbls_pkg::CHAR_PLUS && b1 == tbls_pkg::CHAR_SLASH
                   && b2 == tbls_pkg::CHAR_V
                   && (b3 == tbls_pkg::CHAR_EIGHT || b3 == tbls_pkg::CHAR_NINE
                       || b3 == tbls_pkg::CHAR_PLUS || b3 == tbls_pkg::CHAR_SLASH)) begin
         mark.kind   = tbls_pkg::MARK_UTF7;
         mark.length = tbls_pkg::LEN_BITS'(4);
      end else if (has2 && b0 == tbls_pkg::BYTE_FE && b1 == tbls_pkg::BYTE_FF) begin
         mark.kind   = tbls_pkg::MARK_UTF16BE;
         mark.length = tbls_pkg::LEN_BITS'(2);
      end else if (has2 && b0 == tbls_pkg::BYTE_FF && b1 == tbls_pkg::BYTE_FE) begin
         mark.kind   = tbls_pkg::MARK_UTF16LE;
         mark.length = tbls_pkg::LEN_BITS'(2);
      end
   end

endmodule

@@ rtl/core/tbls_line_tally.sv @@
// ----------------------------------------------------------------------------
// tbls_line_tally
// Saturating LF / CRLF / CR counters with one byte of CR lookahead, and the
// majority vote taken on the closing beat.
// ----------------------------------------------------------------------------
module tbls_line_tally #(
   parameter int COUNT_BITS = tbls_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tbls_pkg::step_ctrl_type          ctrl,
   input  logic [tbls_pkg::BYTE_BITS-1:0]   data_byte,
   input  logic [tbls_pkg::ENDING_BITS-1:0] default_ending,
   output logic [COUNT_BITS-1:0]            lf_count,
   output logic [COUNT_BITS-1:0]            crlf_count,
   output logic [COUNT_BITS-1:0]            cr_count,
   output logic [tbls_pkg::ENDING_BITS-1:0] ending_kind
);

   logic [COUNT_BITS-1:0] lf_ff, crlf_ff, cr_ff;
   logic [COUNT_BITS-1:0] lf_in, crlf_in, cr_in;
   logic                  cr_pending_ff, cr_pending_in;
   logic                  is_lf, is_cr;
   logic [1:0]            cr_step;
   logic [COUNT_BITS:0]   lf_sum, crlf_sum, cr_sum;

   assign is_lf = (data_byte == tbls_pkg::BYTE_LF);
   assign is_cr = (data_byte == tbls_pkg::BYTE_CR);

   // a pending CR not followed by LF is lone; a CR on the closing beat is too
   assign cr_step = {1'b0, cr_pending_ff && !is_lf} + {1'b0, ctrl.last && is_cr};

   assign lf_sum   = {1'b0, lf_ff}   + (COUNT_BITS+1)'(is_lf && !cr_pending_ff);
   assign crlf_sum = {1'b0, crlf_ff} + (COUNT_BITS+1)'(is_lf && cr_pending_ff);
   assign cr_sum   = {1'b0, cr_ff}   + (COUNT_BITS+1)'(cr_step);

   // carry out means the counter ran past its top: pin it there
   assign lf_count   = lf_sum[COUNT_BITS]   ? '1 : lf_sum[COUNT_BITS-1:0];
   assign crlf_count = crlf_sum[COUNT_BITS] ? '1 : crlf_sum[COUNT_BITS-1:0];
   assign cr_count   = cr_sum[COUNT_BITS]   ? '1 : cr_sum[COUNT_BITS-1:0];

   always_comb begin
      if (lf_count > crlf_count && lf_count > cr_count) begin
         ending_kind = tbls_pkg::ENDING_LF;
      end else if (crlf_count > lf_count && crlf_count > cr_count) begin
         ending_kind = tbls_pkg::ENDING_CRLF;
      end else if (cr_count > crlf_count && cr_count > lf_count) begin
         ending_kind = tbls_pkg::ENDING_CR;
      end else if (default_ending == tbls_pkg::ENDING_LF
                   || default_ending == tbls_pkg::ENDING_CRLF
                   || default_ending == tbls_pkg::ENDING_CR) begin
         ending_kind = default_ending;
      end else begin
         ending_kind = tbls_pkg::ENDING_LF;
      end
   end

   always_comb begin
      lf_in         = lf_ff;
      crlf_in       = crlf_ff;
      cr_in         = cr_ff;
      cr_pending_in = cr_pending_ff;
      if (ctrl.advance) begin
         if (ctrl.last) begin
            lf_in         = '0;
            crlf_in       = '0;
            cr_in         = '0;
            cr_pending_in = 1'b0;
         end else begin
            lf_in         = lf_count;
            crlf_in       = crlf_count;
            cr_in         = cr_count;
            cr_pending_in = is_cr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lf_ff         <= '0;
         crlf_ff       <= '0;
         cr_ff         <= '0;
         cr_pending_ff <= 1'b0;
      end else begin
         lf_ff         <= lf_in;
         crlf_ff       <= crlf_in;
         cr_ff         <= cr_in;
         cr_pending_ff <= cr_pending_in;
      end
   end

endmodule

@@ rtl/core/text_bom_and_line_ending_sniffer_unit.sv @@
// ----------------------------------------------------------------------------
// text_bom_and_line_ending_sniffer_unit
// Byte order mark and line ending sniffer for a streamed text buffer.
// ----------------------------------------------------------------------------
// Feed the buffer one byte per beat on req_, with req_tlast on its final
// byte. The unit takes one byte every cycle unless a stalled rsp_ backs it up,
// and holds no per-buffer limit; a byte moves through an input register and
// then through one pass of compare-and-increment logic; the summary is
// registered on rsp_ behind the input register. Only the last byte of a buffer
// yields a beat on rsp_: the byte order mark kind and length found in the
// first four bytes, the lone-LF, CRLF and lone-CR counts (saturating at
// 2^COUNT_BITS-1, reported in 32 bits), and the majority line ending. On a
// tie, or with no line endings at all, csr_write_data's last value is
// reported (a value of 3 reads as LF). All sniffing state clears after each
// summary, so the next buffer starts fresh. Write csr_ only while idle.
// A stalled rsp_ holds up req_ only when a finished summary is waiting and
// another one is about to land.
// ----------------------------------------------------------------------------
module text_bom_and_line_ending_sniffer_unit #(
   parameter int COUNT_BITS = tbls_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   // csr: default line ending
   input  logic                             csr_write_en,
   input  logic [tbls_pkg::ENDING_BITS-1:0] csr_write_data,

   // req: text bytes
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] data_byte
   input  logic                             req_tlast,   // end_of_buffer

   // rsp: per-buffer summary
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] mark_kind, [5:3] mark_length, [7:6] ending_kind,
   // [39:8] lf_total, [71:40] crlf_total, [103:72] cr_total
   output logic [103:0]                     rsp_tdata
);

   localparam int TB = tbls_pkg::TOTAL_BITS;

   // csr
   logic [tbls_pkg::ENDING_BITS-1:0] default_ending_ff;

   // input register
   logic                           in_valid_ff;
   logic [tbls_pkg::BYTE_BITS-1:0] in_byte_ff;
   logic                           in_last_ff;

   // head capture
   logic [tbls_pkg::HEAD_BITS-1:0] head_ff, head_in, head_next;
   logic [tbls_pkg::SEEN_BITS-1:0] seen_ff, seen_in, seen_next;

   // result register
   logic         rsp_valid_ff;
   logic [103:0] rsp_data_ff, rsp_data_in;

   tbls_pkg::step_ctrl_type ctrl;
   tbls_pkg::mark_type      mark;
   logic                    advance;

   logic [COUNT_BITS-1:0]            lf_count, crlf_count, cr_count;
   logic [tbls_pkg::ENDING_BITS-1:0] ending_kind;
   logic [COUNT_BITS+TB-1:0]         lf_wide, crlf_wide, cr_wide;

   // a non-final byte always moves on; a final one needs room in rsp
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign ctrl.advance = advance;
   assign ctrl.last    = in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_ending_ff <= tbls_pkg::ENDING_LF;
      end else if (csr_write_en) begin
         default_ending_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[tbls_pkg::BYTE_BITS-1:0];
         in_last_ff <= req_tlast;
      end
   end

   // first four bytes land in lane order; later bytes leave the head alone
   always_comb begin
      for (int i = 0; i < tbls_pkg::HEAD_BYTES; i++) begin
         head_next[i*tbls_pkg::BYTE_BITS +: tbls_pkg::BYTE_BITS] =
            (seen_ff < tbls_pkg::SEEN_BITS'(tbls_pkg::HEAD_BYTES)
             && seen_ff[1:0] == 2'(i))
            ? in_byte_ff
            : head_ff[i*tbls_pkg::BYTE_BITS +: tbls_pkg::BYTE_BITS];
      end
   end

   assign seen_next = (seen_ff < tbls_pkg::SEEN_BITS'(tbls_pkg::HEAD_BYTES))
                    ? seen_ff + tbls_pkg::SEEN_BITS'(1) : seen_ff;

   always_comb begin
      head_in = head_ff;
      seen_in = seen_ff;
      if (advance) begin
         head_in = in_last_ff ? '0 : head_next;
         seen_in = in_last_ff ? '0 : seen_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         seen_ff <= '0;
      end else begin
         head_ff <= head_in;
         seen_ff <= seen_in;
      end
   end

   tbls_mark_decode u_mark (
      .head_bytes (head_next),
      .bytes_seen (seen_next),
      .mark       (mark)
   );

   tbls_line_tally #(
      .COUNT_BITS (COUNT_BITS)
   ) u_tally (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .data_byte      (in_byte_ff),
      .default_ending (default_ending_ff),
      .lf_count       (lf_count),
      .crlf_count     (crlf_count),
      .cr_count       (cr_count),
      .ending_kind    (ending_kind)
   );

   // totals are reported in 32 bits whatever the counter width
   assign lf_wide   = {{TB{1'b0}}, lf_count};
   assign crlf_wide = {{TB{1'b0}}, crlf_count};
   assign cr_wide   = {{TB{1'b0}}, cr_count};

   assign rsp_data_in = {cr_wide[TB-1:0], crlf_wide[TB-1:0], lf_wide[TB-1:0],
                         ending_kind, mark.length, mark.kind};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the BOM / line ending sniffer. A directed script
// hits each mark kind, the CR lookahead cases and a one-byte buffer, then
// random buffers run under four default endings. A behavioral model of the
// sniffer predicts every summary; bursty input and a stalling output side
// shake the handshakes, with one long output hold to back the unit up.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [tbls_pkg::ENDING_BITS-1:0] ENDING_UNUSED = 2'd3;   // reported as LF
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int PHASE_BYTES      = 440;
   localparam int SCRIPT_ROWS      = 25;

   // one summary beat, laid out as rsp_tdata
   typedef struct packed {
      logic [tbls_pkg::TOTAL_BITS-1:0]  cr_total;
      logic [tbls_pkg::TOTAL_BITS-1:0]  crlf_total;
      logic [tbls_pkg::TOTAL_BITS-1:0]  lf_total;
      logic [tbls_pkg::ENDING_BITS-1:0] ending;
      logic [tbls_pkg::LEN_BITS-1:0]    length;
      logic [tbls_pkg::KIND_BITS-1:0]   kind;
   } summary_type;

   // directed row: typed = 1 means the summary below is the expectation
   typedef struct packed {
      logic [7:0]                       data;
      logic                             last;
      logic                             typed;
      logic [tbls_pkg::KIND_BITS-1:0]   kind;
      logic [tbls_pkg::LEN_BITS-1:0]    length;
      logic [tbls_pkg::ENDING_BITS-1:0] ending;
      logic [7:0]                       lf;
      logic [7:0]                       crlf;
      logic [7:0]                       cr;
   } script_row_type;

   localparam script_row_type DIRECTED_SCRIPT [SCRIPT_ROWS] = '{
      // one-byte buffer right after reset
      '{tbls_pkg::BYTE_ZERO, 1'b1, 1'b1, tbls_pkg::MARK_NONE, 3'd0, tbls_pkg::ENDING_LF,
        8'd0, 8'd0, 8'd0},
      // UTF-8 mark, nothing after it
      '{tbls_pkg::BYTE_EF,    1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_BB,    1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_BF,    1'b1, 1'b1, tbls_pkg::MARK_UTF8, 3'd3, tbls_pkg::ENDING_LF,
        8'd0, 8'd0, 8'd0},
      // UTF-32BE
      '{tbls_pkg::BYTE_ZERO,  1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_ZERO,  1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_FE,    1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_FF,    1'b1, 1'b1, tbls_pkg::MARK_UTF32BE, 3'd4, tbls_pkg::ENDING_LF,
        8'd0, 8'd0, 8'd0},
      // UTF-32LE wins over the UTF-16LE prefix
      '{tbls_pkg::BYTE_FF,    1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_FE,    1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_ZERO,  1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_ZERO,  1'b1, 1'b1, tbls_pkg::MARK_UTF32LE, 3'd4, tbls_pkg::ENDING_LF,
        8'd0, 8'd0, 8'd0},
      // UTF-7, CR still pending at the last byte counts as lone
      '{tbls_pkg::CHAR_PLUS,  1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::CHAR_SLASH, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::CHAR_V,     1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::CHAR_EIGHT, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_CR,    1'b1, 1'b1, tbls_pkg::MARK_UTF7, 3'd4, tbls_pkg::ENDING_CR,
        8'd0, 8'd0, 8'd1},
      // UTF-16BE, two-byte buffer
      '{tbls_pkg::BYTE_FE,    1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_FF,    1'b1, 1'b1, tbls_pkg::MARK_UTF16BE, 3'd2, tbls_pkg::ENDING_LF,
        8'd0, 8'd0, 8'd0},
      // UTF-16LE, CR CR LF LF: lone CR, CRLF, lone LF, three-way tie
      '{tbls_pkg::BYTE_FF,    1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_FE,    1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_CR,    1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_CR,    1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_LF,    1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{tbls_pkg::BYTE_LF,    1'b1, 1'b0, '0, '0, '0, '0, '0, '0}
   };

   localparam logic [tbls_pkg::ENDING_BITS-1:0] PHASE_DEFAULTS [4] =
      '{tbls_pkg::ENDING_CR, tbls_pkg::ENDING_CRLF, ENDING_UNUSED, tbls_pkg::ENDING_LF};

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_write_en = 1'b0;
   logic [tbls_pkg::ENDING_BITS-1:0] csr_write_data = tbls_pkg::ENDING_LF;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata = 8'h00;
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [103:0]                     rsp_tdata;

   text_bom_and_line_ending_sniffer_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

   always #5 clock = ~clock;

   initial begin : watchdog
      #8000000;
      $display("testbench: errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sniffer model: head bytes, CR lookahead, saturating tallies
   // ---------------------------------------------------------------------
   logic [tbls_pkg::ENDING_BITS-1:0] tie_ending = tbls_pkg::ENDING_LF;
   logic [7:0]                       head [tbls_pkg::HEAD_BYTES];
   logic [tbls_pkg::SEEN_BITS-1:0]   seen_n = '0;
   logic                             cr_open = 1'b0;
   logic [tbls_pkg::TOTAL_BITS-1:0]  lf_n = '0, crlf_n = '0, cr_n = '0;

   summary_type summaries_due [$];
   int          mismatch_count = 0;
   bit          long_hold_due = 1'b0;

   function automatic logic [tbls_pkg::TOTAL_BITS-1:0] bump(
      input logic [tbls_pkg::TOTAL_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic void sniff_byte(input logic [7:0] b, input logic last,
                                      output logic done, output summary_type s);
      logic [tbls_pkg::KIND_BITS-1:0]   kind;
      logic [tbls_pkg::LEN_BITS-1:0]    len;
      logic [tbls_pkg::ENDING_BITS-1:0] ending;
      done = 1'b0;
      s = '0;
      kind = tbls_pkg::MARK_NONE;
      len = '0;
      if (seen_n < tbls_pkg::HEAD_BYTES) begin
         head[seen_n[1:0]] = b;
         seen_n = seen_n + 1'b1;
      end
      if (b == tbls_pkg::BYTE_LF) begin
         if (cr_open) begin
            crlf_n = bump(crlf_n);
            cr_open = 1'b0;
         end else begin
            lf_n = bump(lf_n);
         end
      end else if (b == tbls_pkg::BYTE_CR) begin
         if (cr_open) cr_n = bump(cr_n);   // first CR of a CR CR pair is lone
         cr_open = 1'b1;
      end else if (cr_open) begin
         cr_n = bump(cr_n);
         cr_open = 1'b0;
      end
      if (!last) return;

      if (cr_open) cr_n = bump(cr_n);

      if (seen_n >= 3 && head[0] == tbls_pkg::BYTE_EF && head[1] == tbls_pkg::BYTE_BB
          && head[2] == tbls_pkg::BYTE_BF) begin
         kind = tbls_pkg::MARK_UTF8;    len = 3'd3;
      end else if (seen_n == 4 && head[0] == tbls_pkg::BYTE_ZERO
                   && head[1] == tbls_pkg::BYTE_ZERO
                   && head[2] == tbls_pkg::BYTE_FE && head[3] == tbls_pkg::BYTE_FF) begin
         kind = tbls_pkg::MARK_UTF32BE; len = 3'd4;
      end else if (seen_n == 4 && head[0] == tbls_pkg::BYTE_FF && head[1] == tbls_pkg::BYTE_FE
                   && head[2] == tbls_pkg::BYTE_ZERO
                   && head[3] == tbls_pkg::BYTE_ZERO) begin
         kind = tbls_pkg::MARK_UTF32LE; len = 3'd4;
      end else if (seen_n == 4 && head[0] == tbls_pkg::CHAR_PLUS
                   && head[1] == tbls_pkg::CHAR_SLASH && head[2] == tbls_pkg::CHAR_V
                   && (head[3] == tbls_pkg::CHAR_EIGHT || head[3] == tbls_pkg::CHAR_NINE
                       || head[3] == tbls_pkg::CHAR_PLUS
                       || head[3] == tbls_pkg::CHAR_SLASH)) begin
         kind = tbls_pkg::MARK_UTF7;    len = 3'd4;
      end else if (seen_n >= 2 && head[0] == tbls_pkg::BYTE_FE
                   && head[1] == tbls_pkg::BYTE_FF) begin
         kind = tbls_pkg::MARK_UTF16BE; len = 3'd2;
      end else if (seen_n >= 2 && head[0] == tbls_pkg::BYTE_FF
                   && head[1] == tbls_pkg::BYTE_FE) begin
         kind = tbls_pkg::MARK_UTF16LE; len = 3'd2;
      end

      if (lf_n > crlf_n && lf_n > cr_n)        ending = tbls_pkg::ENDING_LF;
      else if (crlf_n > lf_n && crlf_n > cr_n) ending = tbls_pkg::ENDING_CRLF;
      else if (cr_n > crlf_n && cr_n > lf_n)   ending = tbls_pkg::ENDING_CR;
      else ending = (tie_ending == ENDING_UNUSED) ? tbls_pkg::ENDING_LF : tie_ending;

      s.kind       = kind;
      s.length     = len;
      s.ending     = ending;
      s.lf_total   = lf_n;
      s.crlf_total = crlf_n;
      s.cr_total   = cr_n;
      done = 1'b1;

      foreach (head[i]) head[i] = tbls_pkg::BYTE_ZERO;
      seen_n = '0;
      cr_open = 1'b0;
      lf_n = '0;
      crlf_n = '0;
      cr_n = '0;
   endfunction

   // ---------------------------------------------------------------------
   // Byte sender: bursts of random length, random gaps between them
   // ---------------------------------------------------------------------
   int unsigned burst_left = 0;
   logic [7:0]  text_q [$];

   task automatic send_byte(input logic [7:0] b, input logic last,
                            output logic done, output summary_type s);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 20);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sniff_byte(b, last, done, s);
   endtask

   // drop valid, let every summary drain, then let the pipe settle
   task automatic drain;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (summaries_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_tie_ending(input logic [tbls_pkg::ENDING_BITS-1:0] v);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      tie_ending = v;
   endtask

   // random buffer: often a mark or a near miss up front, body rich in CR/LF
   task automatic make_text;
      int unsigned body;
      int unsigned pick;
      text_q.delete();
      case ($urandom_range(0, 9))
         0: text_q = '{tbls_pkg::BYTE_EF, tbls_pkg::BYTE_BB, tbls_pkg::BYTE_BF};
         1: text_q = '{tbls_pkg::BYTE_ZERO, tbls_pkg::BYTE_ZERO,
                       tbls_pkg::BYTE_FE, tbls_pkg::BYTE_FF};
         2: text_q = '{tbls_pkg::BYTE_FF, tbls_pkg::BYTE_FE,
                       tbls_pkg::BYTE_ZERO, tbls_pkg::BYTE_ZERO};
         3: begin
            text_q = '{tbls_pkg::CHAR_PLUS, tbls_pkg::CHAR_SLASH, tbls_pkg::CHAR_V};
            case ($urandom_range(0, 3))
               0: text_q.push_back(tbls_pkg::CHAR_EIGHT);
               1: text_q.push_back(tbls_pkg::CHAR_NINE);
               2: text_q.push_back(tbls_pkg::CHAR_PLUS);
               default: text_q.push_back(tbls_pkg::CHAR_SLASH);
            endcase
         end
         4: text_q = '{tbls_pkg::BYTE_FE, tbls_pkg::BYTE_FF};
         5: text_q = '{tbls_pkg::BYTE_FF, tbls_pkg::BYTE_FE};
         6, 7: begin
            // near miss: a mark cut short or with one byte spoiled
            case ($urandom_range(0, 3))
               0: text_q = '{tbls_pkg::BYTE_EF, tbls_pkg::BYTE_BB, tbls_pkg::BYTE_BF};
               1: text_q = '{tbls_pkg::BYTE_ZERO, tbls_pkg::BYTE_ZERO,
                             tbls_pkg::BYTE_FE, tbls_pkg::BYTE_FF};
               2: text_q = '{tbls_pkg::BYTE_FF, tbls_pkg::BYTE_FE,
                             tbls_pkg::BYTE_ZERO, tbls_pkg::BYTE_ZERO};
               default: text_q = '{tbls_pkg::CHAR_PLUS, tbls_pkg::CHAR_SLASH,
                                   tbls_pkg::CHAR_V, tbls_pkg::CHAR_NINE};
            endcase
            if ($urandom_range(0, 1)) void'(text_q.pop_back());
            else text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
         end
         default: ;
      endcase
      body = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 10);
      repeat (body) begin
         pick = $urandom_range(0, 9);
         if (pick < 3)      text_q.push_back(tbls_pkg::BYTE_LF);
         else if (pick < 6) text_q.push_back(tbls_pkg::BYTE_CR);
         else               text_q.push_back(8'($urandom_range(0, 255)));
      end
      if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      script_row_type row;
      summary_type    s;
      logic           done;
      int unsigned    sent;
      foreach (head[i]) head[i] = tbls_pkg::BYTE_ZERO;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed script at the reset default (LF)
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         row = DIRECTED_SCRIPT[i];
         send_byte(row.data, row.last, done, s);
         if (row.typed) begin
            s.kind       = row.kind;
            s.length     = row.length;
            s.ending     = row.ending;
            s.lf_total   = tbls_pkg::TOTAL_BITS'(row.lf);
            s.crlf_total = tbls_pkg::TOTAL_BITS'(row.crlf);
            s.cr_total   = tbls_pkg::TOTAL_BITS'(row.cr);
         end
         if (done) summaries_due.push_back(s);
      end
      drain();

      // random buffers, one tie default per phase
      for (int p = 0; p < 4; p++) begin
         set_tie_ending(PHASE_DEFAULTS[p]);
         if (p == 0) long_hold_due = 1'b1;
         sent = 0;
         while (sent < PHASE_BYTES) begin
            make_text();
            foreach (text_q[i]) begin
               send_byte(text_q[i], i == text_q.size() - 1, done, s);
               if (done) summaries_due.push_back(s);
            end
            sent += text_q.size();
         end
         drain();
      end

      if (mismatch_count == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Summary receiver: stalls in spans of random duty, one long hold-off
   // ---------------------------------------------------------------------
   initial begin : rsp_stall_pattern
      int unsigned span;
      int unsigned duty;
      forever begin
         span = $urandom_range(4, 80);
         case ($urandom_range(0, 3))
            0: duty = 100;
            1: duty = 70;
            2: duty = 40;
            default: duty = 10;
         endcase
         repeat (span) begin
            @(posedge clock);
            if (long_hold_due) begin
               // sender keeps going; summaries pile up and req_tready drops
               rsp_tready <= 1'b0;
               long_hold_due = 1'b0;
               repeat (LONG_HOLD_CYCLES) @(posedge clock);
            end
            rsp_tready <= ($urandom_range(1, 100) <= duty);
         end
      end
   end

   task automatic check_field(input string what, input logic [tbls_pkg::TOTAL_BITS-1:0] want,
                              input logic [tbls_pkg::TOTAL_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : summary_check
      summary_type got;
      summary_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (summaries_due.size() == 0) begin
            $display("%0t unexpected summary: expected none actual %0h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = summaries_due.pop_front();
            check_field("mark_kind",   tbls_pkg::TOTAL_BITS'(want.kind),
                        tbls_pkg::TOTAL_BITS'(got.kind));
            check_field("mark_length", tbls_pkg::TOTAL_BITS'(want.length),
                        tbls_pkg::TOTAL_BITS'(got.length));
            check_field("ending_kind", tbls_pkg::TOTAL_BITS'(want.ending),
                        tbls_pkg::TOTAL_BITS'(got.ending));
            check_field("lf_total",    want.lf_total,   got.lf_total);
            check_field("crlf_total",  want.crlf_total, got.crlf_total);
            check_field("cr_total",    want.cr_total,   got.cr_total);
         end
      end
   end

endmodule
